@@ hdl/hbs_pkg.sv @@
// Shared types and constants for the 3x3 heightmap box smoothing block.
// No dependencies; every other file refers to it by scoped names.
package hbs_pkg;

    localparam int SAMPLE_W      = 8;
    localparam int MEAN_W        = 16;
    localparam int SUM_W         = 12;
    localparam int CNT_W         = 4;
    localparam int CFG_WIDTH_W   = 11;
    localparam int CFG_HEIGHT_W  = 13;
    localparam int APB_DATA_W    = 32;
    localparam int APB_ADDR_W    = 3;

    localparam int MAX_WIDTH_DEF  = 1024;
    localparam int MAX_HEIGHT_DEF = 4096;
    localparam int FRAC_BITS_DEF  = 8;

    localparam logic [CFG_WIDTH_W-1:0]  MAP_WIDTH_RST  = 11'd1024;
    localparam logic [CFG_HEIGHT_W-1:0] MAP_HEIGHT_RST = 13'd1024;

    localparam logic REG_MAP_WIDTH  = 1'b0;
    localparam logic REG_MAP_HEIGHT = 1'b1;

    typedef struct packed {
        logic [CFG_WIDTH_W-1:0]  map_width;
        logic [CFG_HEIGHT_W-1:0] map_height;
    } hbs_cfg_t;

    typedef struct packed {
        logic [SAMPLE_W-1:0] upper;
        logic [SAMPLE_W-1:0] middle;
    } hbs_line_t;

    typedef struct packed {
        logic start;
        logic ack;
    } hbs_div_req_t;

    typedef struct packed {
        logic busy;
        logic done;
    } hbs_div_stat_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_UPDATE,
        ST_SUM,
        ST_DIV
    } hbs_state_t;

endpackage

@@ hdl/hbs_if.sv @@
// Valid/ready stream interfaces for sample requests and result requests.
// Depends on hbs_pkg for payload widths.
interface hbs_in_if;
    logic                         valid;
    logic                         ready;
    logic                         action;
    logic [hbs_pkg::SAMPLE_W-1:0] height_sample;

    modport source (output valid, output action, output height_sample, input ready);
    modport sink   (input valid, input action, input height_sample, output ready);
endinterface

interface hbs_out_if;
    logic                       valid;
    logic                       ready;
    logic [hbs_pkg::MEAN_W-1:0] mean_height;
    logic                       frame_last;

    modport source (output valid, output mean_height, output frame_last, input ready);
    modport sink   (input valid, input mean_height, input frame_last, output ready);
endinterface

@@ hdl/heightmap_box_smooth_3x3.sv @@
// Top level of the 3x3 heightmap box smoothing block.
// Depends on hbs_pkg, hbs_if, hbs_cfg, hbs_line_mem and hbs_div.
//
// Usage: samples (valid/ready) carries raw 8-bit height samples of a frame in
// row-major order; action marks flush items, which follow the last sample to
// drain the tail (map_width+1 of them). results (valid/ready) carries the
// Q8.8 neighbourhood mean and frame_last. The APB port holds map_width at
// byte address 0 and map_height at 4; write them only while the block is idle.
// A result appears for each request once map_width+1 requests have filled the
// line buffer, so results trail samples by map_width+1 requests.
// A request that gives no result passes through accept and a line buffer
// read-modify-write; one that gives a result passes through accept, line
// buffer update, window sum, multiply by the reciprocal of the count and
// result load into the result register, which presents it.
// Reset clears counters, window and handshakes; the line buffer is never
// cleared; stale entries only reach window rows that the border masks drop.
// A stalled receiver holds the result register; the next request is still
// taken and worked until its result needs that register.
module heightmap_box_smooth_3x3
#(
    parameter int MAX_WIDTH  = hbs_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = hbs_pkg::MAX_HEIGHT_DEF,
    parameter int FRAC_BITS  = hbs_pkg::FRAC_BITS_DEF
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    hbs_in_if.sink                           samples,
    hbs_out_if.source                        results,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [hbs_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [hbs_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [hbs_pkg::APB_DATA_W-1:0]   prdata,
    output logic                             pready
);

    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int WID_W  = $clog2(MAX_WIDTH + 1);
    localparam int ROW_W  = $clog2(MAX_HEIGHT + 1);
    localparam int STC_W  = $clog2(MAX_WIDTH + 2);
    localparam int NUM_W  = hbs_pkg::SUM_W + FRAC_BITS;
    localparam int WCMP_W = (WID_W > hbs_pkg::CFG_WIDTH_W) ? WID_W : hbs_pkg::CFG_WIDTH_W;
    localparam int HCMP_W = (ROW_W > hbs_pkg::CFG_HEIGHT_W) ? ROW_W : hbs_pkg::CFG_HEIGHT_W;
    localparam int SW     = hbs_pkg::SAMPLE_W;

    hbs_pkg::hbs_cfg_t       cfg;
    hbs_pkg::hbs_state_t     state_reg;
    hbs_pkg::hbs_state_t     state_next;
    hbs_pkg::hbs_div_req_t   div_req;
    hbs_pkg::hbs_div_stat_t  div_stat;
    hbs_pkg::hbs_line_t      line_rd;
    hbs_pkg::hbs_line_t      line_wr;

    logic [NUM_W-1:0]        div_num;
    logic [NUM_W-1:0]        div_quo;
    logic [NUM_W+hbs_pkg::MEAN_W-1:0] quo_ext;

    logic [SW-1:0]           win_reg [3][3];
    logic [ROW_W-1:0]        input_row_reg;
    logic [COL_W-1:0]        input_col_reg;
    logic [ROW_W-1:0]        output_row_reg;
    logic [COL_W-1:0]        output_col_reg;
    logic [STC_W-1:0]        startup_reg;
    logic                    act_reg;
    logic [SW-1:0]           samp_reg;
    logic                    last_reg;
    logic                    out_valid_reg;
    logic [hbs_pkg::MEAN_W-1:0] out_mean_reg;
    logic                    out_last_reg;

    logic [WCMP_W-1:0]       wcfg;
    logic [HCMP_W-1:0]       hcfg;
    logic [WID_W-1:0]        w_eff;
    logic [ROW_W-1:0]        h_eff;

    logic                    accept;
    logic                    drop;
    logic                    in_ready;
    logic                    mem_re;
    logic                    mem_we;
    logic                    out_load;
    logic                    filling;

    logic                    past;
    logic [SW-1:0]           val;
    logic                    wrap0;
    logic                    wrap1;
    logic [COL_W-1:0]        ic0;
    logic [WID_W-1:0]        ic1;
    logic [ROW_W-1:0]        row_a;
    logic [ROW_W-1:0]        row_b;
    logic [COL_W-1:0]        in_col_next;

    logic                    wrapo;
    logic [COL_W-1:0]        ocol_a;
    logic [ROW_W:0]          orow_a;
    logic [ROW_W-1:0]        orow_c;
    logic [2:0]              row_en;
    logic [2:0]              col_en;
    logic [1:0]              rows_n;
    logic [1:0]              cols_n;
    logic [hbs_pkg::CNT_W-1:0] cnt;
    logic [hbs_pkg::SUM_W-1:0] sum;
    logic                    sum_last;
    logic [WID_W-1:0]        ocol_inc;
    logic                    wrap_n;
    logic [COL_W-1:0]        out_col_next;
    logic [ROW_W-1:0]        out_row_next;

    hbs_cfg u_cfg
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    hbs_line_mem #(.DEPTH(MAX_WIDTH)) u_line_mem
    (
        .clk     (clk),
        .rd_en   (mem_re),
        .rd_addr (ic0),
        .rd_data (line_rd),
        .wr_en   (mem_we),
        .wr_addr (ic0),
        .wr_data (line_wr)
    );

    hbs_div #(.NUM_W(NUM_W)) u_div
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .num   (div_num),
        .den   (cnt),
        .stat  (div_stat),
        .quo   (div_quo)
    );

    // effective geometry
    assign wcfg  = WCMP_W'(cfg.map_width);
    assign hcfg  = HCMP_W'(cfg.map_height);
    assign w_eff = (wcfg == '0) ? WID_W'(1) :
                   (wcfg > WCMP_W'(MAX_WIDTH)) ? WID_W'(MAX_WIDTH) : WID_W'(wcfg);
    assign h_eff = (hcfg == '0) ? ROW_W'(1) :
                   (hcfg > HCMP_W'(MAX_HEIGHT)) ? ROW_W'(MAX_HEIGHT) : ROW_W'(hcfg);

    assign accept = samples.valid && samples.ready;
    assign drop   = samples.action && (input_row_reg == '0) && (input_col_reg == '0)
                    && (startup_reg == '0);

    // input side: column, row and sample value
    assign past  = input_row_reg >= h_eff;
    assign val   = (act_reg || past) ? '0 : samp_reg;
    assign wrap0 = WID_W'(input_col_reg) >= w_eff;
    assign ic0   = wrap0 ? '0 : input_col_reg;
    assign row_a = (wrap0 && (input_row_reg < h_eff)) ? input_row_reg + ROW_W'(1)
                                                       : input_row_reg;
    assign ic1   = WID_W'(ic0) + WID_W'(1);
    assign wrap1 = ic1 >= w_eff;
    assign row_b = (wrap1 && (row_a < h_eff)) ? row_a + ROW_W'(1) : row_a;
    assign in_col_next = wrap1 ? '0 : ic1[COL_W-1:0];
    assign filling     = startup_reg < (STC_W'(w_eff) + STC_W'(1));

    assign line_wr.upper  = line_rd.middle;
    assign line_wr.middle = val;

    // output side: position, border masks and window sum
    assign wrapo  = WID_W'(output_col_reg) >= w_eff;
    assign ocol_a = wrapo ? '0 : output_col_reg;
    assign orow_a = (ROW_W+1)'(output_row_reg) + (ROW_W+1)'(wrapo);
    assign orow_c = (orow_a >= (ROW_W+1)'(h_eff)) ? h_eff - ROW_W'(1) : orow_a[ROW_W-1:0];

    assign row_en[0] = orow_c != '0;
    assign row_en[1] = 1'b1;
    assign row_en[2] = ((ROW_W+1)'(orow_c) + (ROW_W+1)'(1)) < (ROW_W+1)'(h_eff);
    assign col_en[0] = ocol_a != '0;
    assign col_en[1] = 1'b1;
    assign col_en[2] = (WID_W'(ocol_a) + WID_W'(1)) < w_eff;

    assign rows_n = 2'd1 + 2'(row_en[0]) + 2'(row_en[2]);
    assign cols_n = 2'd1 + 2'(col_en[0]) + 2'(col_en[2]);
    assign cnt    = hbs_pkg::CNT_W'(rows_n) * hbs_pkg::CNT_W'(cols_n);

    always_comb
    begin
        sum = '0;
        for (int r = 0; r < 3; r++)
        begin
            for (int c = 0; c < 3; c++)
            begin
                if (row_en[r] && col_en[c])
                begin
                    sum = sum + hbs_pkg::SUM_W'(win_reg[r][c]);
                end
            end
        end
    end

    assign sum_last = (orow_c == h_eff - ROW_W'(1)) && (WID_W'(ocol_a) == w_eff - WID_W'(1));
    assign ocol_inc = WID_W'(ocol_a) + WID_W'(1);
    assign wrap_n   = ocol_inc >= w_eff;
    assign out_col_next = wrap_n ? '0 : ocol_inc[COL_W-1:0];
    assign out_row_next = wrap_n ? orow_c + ROW_W'(1) : orow_c;

    assign div_num = (NUM_W'(sum) << FRAC_BITS) + NUM_W'(cnt >> 1);
    assign quo_ext = (NUM_W+hbs_pkg::MEAN_W)'(div_quo);

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            hbs_pkg::ST_IDLE:
                if (accept && !drop)
                begin
                    state_next = hbs_pkg::ST_UPDATE;
                end
            hbs_pkg::ST_UPDATE:
                state_next = filling ? hbs_pkg::ST_IDLE : hbs_pkg::ST_SUM;
            hbs_pkg::ST_SUM:
                state_next = hbs_pkg::ST_DIV;
            hbs_pkg::ST_DIV:
                if (out_load)
                begin
                    state_next = hbs_pkg::ST_IDLE;
                end
            default:
                state_next = hbs_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        in_ready      = 1'b0;
        mem_re        = 1'b0;
        mem_we        = 1'b0;
        div_req.start = 1'b0;
        out_load      = 1'b0;
        case (state_reg)
            hbs_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                mem_re   = samples.valid;
            end
            hbs_pkg::ST_UPDATE:
                mem_we = 1'b1;
            hbs_pkg::ST_SUM:
                div_req.start = 1'b1;
            hbs_pkg::ST_DIV:
                out_load = div_stat.done && (!out_valid_reg || results.ready);
            default:
                in_ready = 1'b0;
        endcase
        div_req.ack = out_load;
    end

    assign samples.ready = in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= hbs_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            input_row_reg  <= '0;
            input_col_reg  <= '0;
            output_row_reg <= '0;
            output_col_reg <= '0;
            startup_reg    <= '0;
            for (int r = 0; r < 3; r++)
            begin
                for (int c = 0; c < 3; c++)
                begin
                    win_reg[r][c] <= '0;
                end
            end
        end
        else if (state_reg == hbs_pkg::ST_UPDATE)
        begin
            for (int r = 0; r < 3; r++)
            begin
                win_reg[r][0] <= win_reg[r][1];
                win_reg[r][1] <= win_reg[r][2];
            end
            win_reg[0][2] <= line_rd.upper;
            win_reg[1][2] <= line_rd.middle;
            win_reg[2][2] <= val;
            input_col_reg <= in_col_next;
            input_row_reg <= row_b;
            if (filling)
            begin
                startup_reg <= startup_reg + STC_W'(1);
            end
        end
        else if (state_reg == hbs_pkg::ST_SUM)
        begin
            if (sum_last)
            begin
                input_row_reg  <= '0;
                input_col_reg  <= '0;
                output_row_reg <= '0;
                output_col_reg <= '0;
                startup_reg    <= '0;
            end
            else
            begin
                output_row_reg <= out_row_next;
                output_col_reg <= out_col_next;
            end
        end
    end

    // hold request payload and frame end flag
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            act_reg  <= samples.action;
            samp_reg <= samples.height_sample;
        end
        if (state_reg == hbs_pkg::ST_SUM)
        begin
            last_reg <= sum_last;
        end
        if (out_load)
        begin
            out_mean_reg <= quo_ext[hbs_pkg::MEAN_W-1:0];
            out_last_reg <= last_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (results.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign results.valid       = out_valid_reg;
    assign results.mean_height = out_mean_reg;
    assign results.frame_last  = out_last_reg;

    a_idle_div_free: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == hbs_pkg::ST_IDLE) |-> (!div_stat.busy && !div_stat.done))
        else $error("divider still occupied while sequencer idle");

    a_update_after_request: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == hbs_pkg::ST_UPDATE) |-> $past(samples.valid && samples.ready))
        else $error("line buffer update without an accepted request");

    a_frame_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == hbs_pkg::ST_SUM && sum_last) |=>
        (input_row_reg == '0 && input_col_reg == '0 && startup_reg == '0
         && output_row_reg == '0 && output_col_reg == '0))
        else $error("counters not cleared after frame end");

endmodule

@@ hdl/hbs_cfg.sv @@
// APB register file holding map_width and map_height.
// Depends on hbs_pkg.
module hbs_cfg
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [hbs_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [hbs_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [hbs_pkg::APB_DATA_W-1:0]   prdata,
    output logic                             pready,
    output hbs_pkg::hbs_cfg_t                cfg
);

    logic [hbs_pkg::CFG_WIDTH_W-1:0]  map_width_reg;
    logic [hbs_pkg::CFG_HEIGHT_W-1:0] map_height_reg;
    logic                             wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            map_width_reg  <= hbs_pkg::MAP_WIDTH_RST;
            map_height_reg <= hbs_pkg::MAP_HEIGHT_RST;
        end
        else if (wr_en)
        begin
            case (paddr[2])
                hbs_pkg::REG_MAP_WIDTH:
                    map_width_reg <= pwdata[hbs_pkg::CFG_WIDTH_W-1:0];
                hbs_pkg::REG_MAP_HEIGHT:
                    map_height_reg <= pwdata[hbs_pkg::CFG_HEIGHT_W-1:0];
                default:
                    map_width_reg <= map_width_reg;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[2])
            hbs_pkg::REG_MAP_WIDTH:  prdata = hbs_pkg::APB_DATA_W'(map_width_reg);
            hbs_pkg::REG_MAP_HEIGHT: prdata = hbs_pkg::APB_DATA_W'(map_height_reg);
            default:                 prdata = '0;
        endcase
    end

    assign cfg.map_width  = map_width_reg;
    assign cfg.map_height = map_height_reg;

endmodule

@@ hdl/hbs_line_mem.sv @@
// Two-row line buffer in one synchronous memory, one read and one write port.
// Depends on hbs_pkg for the entry type.
module hbs_line_mem
#(
    parameter int DEPTH = hbs_pkg::MAX_WIDTH_DEF
)
(
    input  logic                     clk,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output hbs_pkg::hbs_line_t       rd_data,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  hbs_pkg::hbs_line_t       wr_data
);

    hbs_pkg::hbs_line_t mem [DEPTH];
    hbs_pkg::hbs_line_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ hdl/hbs_div.sv @@
// Divider by the neighbourhood count (1, 2, 3, 4, 6 or 9): it first loads the
// operand and reciprocal of the count, then multiplies and keeps the high bits.
// Depends on hbs_pkg for the control structs and count width.
module hbs_div
#(
    parameter int NUM_W = hbs_pkg::SUM_W + hbs_pkg::FRAC_BITS_DEF
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  hbs_pkg::hbs_div_req_t       req,
    input  logic [NUM_W-1:0]            num,
    input  logic [hbs_pkg::CNT_W-1:0]   den,
    output hbs_pkg::hbs_div_stat_t      stat,
    output logic [NUM_W-1:0]            quo
);

    localparam int               SHIFT  = NUM_W + 4;
    localparam int               RCP_W  = SHIFT + 1;
    localparam int               PROD_W = NUM_W + RCP_W;
    localparam logic [63:0]      UNIT   = 64'd1 << SHIFT;
    localparam logic [RCP_W-1:0] RCP_1  = RCP_W'(UNIT);
    localparam logic [RCP_W-1:0] RCP_2  = RCP_W'(UNIT >> 1);
    localparam logic [RCP_W-1:0] RCP_3  = RCP_W'((UNIT + 64'd2) / 64'd3);
    localparam logic [RCP_W-1:0] RCP_4  = RCP_W'(UNIT >> 2);
    localparam logic [RCP_W-1:0] RCP_6  = RCP_W'((UNIT + 64'd5) / 64'd6);
    localparam logic [RCP_W-1:0] RCP_9  = RCP_W'((UNIT + 64'd8) / 64'd9);

    logic                        busy_reg;
    logic                        done_reg;
    logic [NUM_W-1:0]            num_reg;
    logic [RCP_W-1:0]            rcp_reg;
    logic [NUM_W-1:0]            quo_reg;
    logic [RCP_W-1:0]            rcp;
    logic [PROD_W-1:0]           prod;

    always_comb
    begin
        case (den)
            hbs_pkg::CNT_W'(1): rcp = RCP_1;
            hbs_pkg::CNT_W'(2): rcp = RCP_2;
            hbs_pkg::CNT_W'(3): rcp = RCP_3;
            hbs_pkg::CNT_W'(4): rcp = RCP_4;
            hbs_pkg::CNT_W'(6): rcp = RCP_6;
            hbs_pkg::CNT_W'(9): rcp = RCP_9;
            default:            rcp = '0;
        endcase
    end

    assign prod = PROD_W'(num_reg) * PROD_W'(rcp_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else if (req.start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
        end
        else if (busy_reg)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b1;
        end
        else if (req.ack)
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            num_reg <= num;
            rcp_reg <= rcp;
        end
        if (busy_reg)
        begin
            quo_reg <= prod[SHIFT +: NUM_W];
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quo       = quo_reg;

endmodule
